// ===== rtl/dema_pkg.sv =====
// Package for the discrete effects audio mixer.
// Holds the item codes, the rounding modes of the shared multiplier and fixed constants.
// No dependencies.
package dema_pkg;

  localparam int DAC_W     = 8;
  localparam int LINE_W    = 3;
  localparam int NUM_LINES = 8;
  localparam int OUT_W     = 16;
  localparam int LFSR_W    = 17;

  // Sample rate divisor of the jump sweep and its width.
  localparam int DIV_DEN   = 20050;
  localparam int DEN_W     = 15;

  localparam int JUMP_BASE = 240;
  localparam int JUMP_SPAN = 700;
  localparam int OUT_GAIN  = 12000;
  localparam int OUT_MAX   = 32767;
  localparam int OUT_MIN   = -32768;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // How the shared multiplier drops the fraction bits.
  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_CEIL    = 2'd1,
    RM_TRUNC   = 2'd2
  } rnd_mode_t;

endpackage

// ===== rtl/dema_in_if.sv =====
// Input channel of the mixer: effect-line writes and sample ticks.
// Depends on dema_pkg.
interface dema_in_if;
  import dema_pkg::*;
  logic              valid;
  logic              ready;
  logic              op;
  logic [DAC_W-1:0]  dac_sample;
  logic              sample_present;
  logic [LINE_W-1:0] line_index;
  logic              line_level;

  modport source (output valid, op, dac_sample, sample_present, line_index, line_level,
                  input ready);
  modport sink   (input valid, op, dac_sample, sample_present, line_index, line_level,
                  output ready);
endinterface

// ===== rtl/dema_out_if.sv =====
// Result channel of the mixer: one signed audio sample per transfer.
// Depends on dema_pkg.
interface dema_out_if;
  import dema_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] audio_out;

  modport source (output valid, audio_out, input ready);
  modport sink   (input valid, audio_out, output ready);
endinterface

// ===== rtl/dema_mul.sv =====
// Shared fixed-point multiplier of the mixer with a registered, rescaled result.
// Depends on dema_pkg.
module dema_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic signed [FRAC_BITS+3:0]    a,
  input  logic signed [FRAC_BITS+3:0]    b,
  input  dema_pkg::rnd_mode_t            mode,
  output logic signed [2*FRAC_BITS+7:0]  res
);
  import dema_pkg::*;

  localparam int VW = FRAC_BITS + 4;
  localparam int PW = 2 * VW;
  localparam logic signed [PW-1:0] HALF   = PW'(longint'(1) <<< (FRAC_BITS - 1));
  localparam logic signed [PW-1:0] ONE_M1 = PW'((longint'(1) <<< FRAC_BITS) - 1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] bias;
  logic signed [PW-1:0] res_r;

  always_comb begin
    prod = PW'(a) * PW'(b);
    unique case (mode)
      RM_NEAREST: bias = HALF;
      RM_CEIL:    bias = ONE_M1;
      RM_TRUNC:   bias = prod[PW-1] ? ONE_M1 : '0;
      default:    bias = HALF;
    endcase
  end

  // The shift is arithmetic, so nearest and ceiling round the same way for both signs.
  always_ff @(posedge clk) begin
    res_r <= (prod + bias) >>> FRAC_BITS;
  end

  assign res = res_r;
endmodule

// ===== rtl/dema_div.sv =====
// Divider by the sample rate constant for the jump sweep, done as a reciprocal multiply
// in two partial products, low half then high half. Depends on dema_pkg.
module dema_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [FRAC_BITS+9:0] num,
  output logic                 done,
  output logic [FRAC_BITS-1:0] quo
);
  import dema_pkg::*;

  localparam int NB = FRAC_BITS + 10;
  // With a shift of NB+DEN_W bits the rounded-up reciprocal is exact for every NB-bit numerator.
  localparam int SH = NB + DEN_W;
  localparam int MW = NB + 1;
  localparam int HW = (MW + 1) / 2;
  localparam int AW = SH + FRAC_BITS;
  localparam longint RECIP_L = ((longint'(1) <<< SH) + DIV_DEN - 1) / DIV_DEN;
  localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
  localparam logic [HW-1:0] R_LO  = RECIP[HW-1:0];
  localparam logic [HW-1:0] R_HI  = HW'(RECIP[MW-1:HW]);

  logic [NB-1:0]    num_r;
  logic [AW-1:0]    acc_r;
  logic             hi_r;
  logic             busy_r;
  logic             done_r;
  logic [NB+HW-1:0] part;

  always_comb begin
    part = (NB + HW)'(num_r) * (NB + HW)'(hi_r ? R_HI : R_LO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      hi_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        hi_r   <= 1'b0;
      end else if (busy_r) begin
        if (hi_r) begin
          busy_r <= 1'b0;
          hi_r   <= 1'b0;
          done_r <= 1'b1;
        end else begin
          hi_r <= 1'b1;
        end
      end
    end
  end

  // The low half of the reciprocal goes first, the high half is added shifted.
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      acc_r <= '0;
    end else if (busy_r) begin
      if (hi_r) acc_r <= acc_r + (AW'(part) << HW);
      else      acc_r <= AW'(part);
    end
  end

  assign done = done_r;
  assign quo  = acc_r[SH +: FRAC_BITS];
endmodule

// ===== rtl/discrete_effects_audio_mixer.sv =====
// Top level of the discrete effects audio mixer: sequencer, state and output register.
// Depends on dema_pkg, dema_in_if, dema_out_if, dema_mul and dema_div.
//
//   port    | dir | transfer carries
//   --------+-----+-------------------------------------------------------------
//   in_ch   | in  | op, dac_sample, sample_present, line_index, line_level
//   out_ch  | out | audio_out, one per sample tick, none per line write
//
// A line write is finished in the cycle it is accepted. A tick runs its multiplies one at
// a time on the shared multiplier, each through S_MUL then S_WB (three always, four per
// active footstep or stomp envelope, two for the jump), with a pass through S_DIV for the
// reciprocal jump divider when the jump sounds.
// Reset is synchronous and restores all effect state at once.
// The input is ready only while the sequencer is idle; a held result waits in the
// output register and stalls the sequencer only when the next one is finished.
module discrete_effects_audio_mixer #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  dema_in_if.sink     in_ch,
  dema_out_if.source  out_ch
);
  import dema_pkg::*;

  localparam int F  = FRAC_BITS;
  localparam int VW = F + 4;
  localparam int PW = 2 * VW;
  localparam int NB = F + 10;
  localparam int EW = F + 1;
  localparam int LW = F + 2;

  localparam longint ONE_L    = longint'(1) <<< F;
  localparam longint K_DC_L   = (63 * ONE_L + 5000) / 10000;
  localparam longint K_GAIN_L = (17 * ONE_L + 5) / 10;
  localparam longint K_WLP_L  = (ONE_L + 2) / 4;
  localparam longint K_SLP_L  = (ONE_L + 10) / 20;
  localparam longint K_THR_L  = (2 * ONE_L + 500) / 1000;
  localparam longint K_WG_L   = (ONE_L + 2) / 5;
  localparam longint K_JG_L   = (22 * ONE_L + 50) / 100;
  localparam longint K_SG_L   = (ONE_L + 1) / 2;
  localparam longint K_WDEC_L = (60 * ONE_L + 10025) / 20050;
  localparam longint K_JDEC_L = (9 * ONE_L + 10025) / 20050;
  localparam longint K_SDEC_L = (5 * ONE_L + 10025) / 20050;

  localparam logic signed [VW-1:0] ONE_V   = VW'(ONE_L);
  localparam logic signed [VW-1:0] K_DC    = VW'(K_DC_L);
  localparam logic signed [VW-1:0] K_GAIN  = VW'(K_GAIN_L);
  localparam logic signed [VW-1:0] K_WLP   = VW'(K_WLP_L);
  localparam logic signed [VW-1:0] K_SLP   = VW'(K_SLP_L);
  localparam logic signed [VW-1:0] K_WG    = VW'(K_WG_L);
  localparam logic signed [VW-1:0] K_JG    = VW'(K_JG_L);
  localparam logic signed [VW-1:0] K_SG    = VW'(K_SG_L);
  localparam logic signed [VW-1:0] K_WDEC  = VW'(K_WDEC_L);
  localparam logic signed [VW-1:0] K_JDEC  = VW'(K_JDEC_L);
  localparam logic signed [VW-1:0] K_SDEC  = VW'(K_SDEC_L);
  localparam logic signed [VW-1:0] K_OUTG  = VW'(OUT_GAIN);
  localparam logic [EW-1:0]        ENV_ONE = EW'(ONE_L);
  localparam logic [EW-1:0]        K_THR   = EW'(K_THR_L);
  localparam logic [NB-1:0]        N_BASE  = NB'(JUMP_BASE * ONE_L + DIV_DEN / 2);
  localparam logic signed [PW-1:0] SAT_HI  = PW'(OUT_MAX);
  localparam logic signed [PW-1:0] SAT_LO  = PW'(OUT_MIN);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_WB   = 4'b0100,
    S_DIV  = 4'b1000
  } fsm_t;

  typedef enum logic [3:0] {
    ST_DC, ST_GAIN, ST_WLP, ST_WENV, ST_WGAIN, ST_WDEC, ST_JDIV, ST_JSQ,
    ST_JDEC, ST_SLP, ST_SENV, ST_SGAIN, ST_SDEC, ST_OUT
  } step_t;

  fsm_t  state_r, state_nxt;
  step_t step_r, step_nxt, step_after;

  logic                    w_en_r, w_en_nxt, j_en_r, j_en_nxt, s_en_r, s_en_nxt;
  logic [NUM_LINES-1:0]    lines_r, lines_nxt, lines_wr, rising;
  logic signed [LW-1:0]    dc_r, dc_nxt, lp_r, lp_nxt, t_r, t_nxt;
  logic [EW-1:0]           we_r, we_nxt, je_r, je_nxt, se_r, se_nxt;
  logic [F-1:0]            phase_r, phase_nxt;
  logic [LFSR_W-1:0]       lfsr_r, lfsr_nxt;
  logic [F:0]              raw_r, raw_nxt;
  logic signed [VW-1:0]    acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_data_r, out_data_nxt;

  logic signed [VW-1:0]    mul_a, mul_b, res_v, diff_raw, n_v, lp_v;
  logic signed [VW-1:0]    we_v, je_v, se_v, dec_rem;
  rnd_mode_t               mul_mode;
  logic signed [PW-1:0]    mul_res;
  logic                    div_start, div_done;
  logic [NB-1:0]           div_num;
  logic [F-1:0]            div_quo;
  logic                    accept;
  logic [DAC_W-1:0]        byte_v;

  dema_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .mode (mul_mode),
    .res  (mul_res)
  );

  dema_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign in_ch.ready      = (state_r == S_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.audio_out = out_data_r;

  // Shared operand views.
  always_comb begin
    diff_raw = VW'(signed'({1'b0, raw_r})) - VW'(dc_r);
    n_v      = lfsr_r[0] ? ONE_V : -ONE_V;
    lp_v     = VW'(lp_r);
    we_v     = VW'(signed'({1'b0, we_r}));
    je_v     = VW'(signed'({1'b0, je_r}));
    se_v     = VW'(signed'({1'b0, se_r}));
    res_v    = mul_res[VW-1:0];
    div_num  = N_BASE + NB'(je_r) * NB'(JUMP_SPAN);
  end

  always_comb begin
    mul_a    = diff_raw;
    mul_b    = K_DC;
    mul_mode = RM_NEAREST;
    unique case (step_r)
      ST_DC:    begin mul_a = diff_raw; mul_b = K_DC; end
      ST_GAIN:  begin mul_a = diff_raw; mul_b = K_GAIN; end
      ST_WLP:   begin mul_a = n_v - lp_v; mul_b = K_WLP; end
      ST_WENV:  begin mul_a = lp_v; mul_b = we_v; end
      ST_WGAIN: begin mul_a = VW'(t_r); mul_b = K_WG; end
      ST_WDEC:  begin mul_a = we_v; mul_b = K_WDEC; mul_mode = RM_CEIL; end
      ST_JDIV:  begin mul_a = je_v; mul_b = K_JDEC; end
      ST_JSQ:   begin mul_a = phase_r[F-1] ? -K_JG : K_JG; mul_b = je_v; end
      ST_JDEC:  begin mul_a = je_v; mul_b = K_JDEC; mul_mode = RM_CEIL; end
      ST_SLP:   begin mul_a = n_v - lp_v; mul_b = K_SLP; end
      ST_SENV:  begin mul_a = lp_v; mul_b = se_v; end
      ST_SGAIN: begin mul_a = VW'(t_r); mul_b = K_SG; end
      ST_SDEC:  begin mul_a = se_v; mul_b = K_SDEC; mul_mode = RM_CEIL; end
      ST_OUT:   begin mul_a = acc_r; mul_b = K_OUTG; mul_mode = RM_TRUNC; end
      default:  begin mul_a = diff_raw; mul_b = K_DC; end
    endcase
  end

  // Next step of the program, skipping silent envelopes.
  always_comb begin
    unique case (step_r)
      ST_DC:    step_after = ST_GAIN;
      ST_GAIN:  step_after = w_en_r ? ST_WLP : j_en_r ? ST_JDIV : s_en_r ? ST_SLP : ST_OUT;
      ST_WLP:   step_after = ST_WENV;
      ST_WENV:  step_after = ST_WGAIN;
      ST_WGAIN: step_after = ST_WDEC;
      ST_WDEC:  step_after = j_en_r ? ST_JDIV : s_en_r ? ST_SLP : ST_OUT;
      ST_JDIV:  step_after = ST_JSQ;
      ST_JSQ:   step_after = ST_JDEC;
      ST_JDEC:  step_after = s_en_r ? ST_SLP : ST_OUT;
      ST_SLP:   step_after = ST_SENV;
      ST_SENV:  step_after = ST_SGAIN;
      ST_SGAIN: step_after = ST_SDEC;
      ST_SDEC:  step_after = ST_OUT;
      ST_OUT:   step_after = ST_OUT;
      default:  step_after = ST_OUT;
    endcase
  end

  always_comb begin
    byte_v   = in_ch.sample_present ? in_ch.dac_sample : DAC_W'(128);
    lines_wr = lines_r;
    lines_wr[in_ch.line_index] = in_ch.line_level;
    rising   = lines_wr & ~lines_r;
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    w_en_nxt      = w_en_r;
    j_en_nxt      = j_en_r;
    s_en_nxt      = s_en_r;
    lines_nxt     = lines_r;
    dc_nxt        = dc_r;
    lp_nxt        = lp_r;
    t_nxt         = t_r;
    we_nxt        = we_r;
    je_nxt        = je_r;
    se_nxt        = se_r;
    phase_nxt     = phase_r;
    lfsr_nxt      = lfsr_r;
    raw_nxt       = raw_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    dec_rem       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.op == OP_WRITE) begin
            lines_nxt = lines_wr;
            if (rising[0]) we_nxt = ENV_ONE;
            if (rising[1]) begin
              je_nxt    = ENV_ONE;
              phase_nxt = '0;
            end
            if (rising[2]) se_nxt = ENV_ONE;
          end else begin
            raw_nxt   = {byte_v, (F - 7)'(0)};
            lfsr_nxt  = {lfsr_r[0] ^ lfsr_r[3], lfsr_r[LFSR_W-1:1]};
            w_en_nxt  = (we_r > K_THR);
            j_en_nxt  = (je_r > K_THR);
            s_en_nxt  = (se_r > K_THR);
            step_nxt  = ST_DC;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_WB;
      end
      S_WB: begin
        unique case (step_r)
          ST_DC:                        dc_nxt  = dc_r + LW'(res_v);
          ST_GAIN:                      acc_nxt = res_v;
          ST_WLP, ST_SLP:               lp_nxt  = lp_r + LW'(res_v);
          ST_WENV, ST_SENV:             t_nxt   = LW'(res_v);
          ST_WGAIN, ST_JSQ, ST_SGAIN:   acc_nxt = acc_r + res_v;
          ST_WDEC: begin
            dec_rem = we_v - res_v;
            we_nxt  = dec_rem[VW-1] ? '0 : dec_rem[EW-1:0];
          end
          ST_JDEC: begin
            dec_rem = je_v - res_v;
            je_nxt  = dec_rem[VW-1] ? '0 : dec_rem[EW-1:0];
          end
          ST_SDEC: begin
            dec_rem = se_v - res_v;
            se_nxt  = dec_rem[VW-1] ? '0 : dec_rem[EW-1:0];
          end
          ST_OUT: begin
            if (!out_valid_r || out_ch.ready) begin
              out_valid_nxt = 1'b1;
              if (mul_res > SAT_HI)      out_data_nxt = OUT_W'(OUT_MAX);
              else if (mul_res < SAT_LO) out_data_nxt = OUT_W'(OUT_MIN);
              else                       out_data_nxt = mul_res[OUT_W-1:0];
            end
          end
          default: ;
        endcase

        if (step_r == ST_OUT) begin
          if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
        end else begin
          step_nxt = step_after;
          if (step_after == ST_JDIV) begin
            div_start = 1'b1;
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          phase_nxt = phase_r + div_quo;
          step_nxt  = step_after;
          state_nxt = S_MUL;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= ST_DC;
      w_en_r      <= 1'b0;
      j_en_r      <= 1'b0;
      s_en_r      <= 1'b0;
      lines_r     <= '0;
      dc_r        <= LW'(ONE_L);
      lp_r        <= '0;
      we_r        <= '0;
      je_r        <= '0;
      se_r        <= '0;
      phase_r     <= '0;
      lfsr_r      <= LFSR_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      w_en_r      <= w_en_nxt;
      j_en_r      <= j_en_nxt;
      s_en_r      <= s_en_nxt;
      lines_r     <= lines_nxt;
      dc_r        <= dc_nxt;
      lp_r        <= lp_nxt;
      we_r        <= we_nxt;
      je_r        <= je_nxt;
      se_r        <= se_nxt;
      phase_r     <= phase_nxt;
      lfsr_r      <= lfsr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r        <= t_nxt;
    raw_r      <= raw_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // A new result only appears from the final step of a tick.
  a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB && step_r == ST_OUT))
    else $error("result raised outside the final step");

  // A line write finishes in the cycle it is accepted.
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.op == OP_WRITE) |=> (state_r == S_IDLE))
    else $error("line write left the sequencer busy");

  // Envelopes never climb above full scale.
  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (we_r <= ENV_ONE) && (je_r <= ENV_ONE) && (se_r <= ENV_ONE))
    else $error("envelope above full scale");

  // The noise register can never lock up at zero.
  a_lfsr_alive: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_r != '0)
    else $error("noise register reached zero");
endmodule
